// ===== hdl/siren_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// siren_pkg
// Shared constants and types of the siren tone period generator: mode codes,
// limit defaults, divider sizing and the controller/datapath interface.
// ----------------------------------------------------------------------------
package siren_pkg;

	// field widths
	localparam int FREQ_W = 13;
	localparam int TOP_W  = 13;
	localparam int ACC_W  = 25;
	localparam int BTN_W  = 4;
	localparam int MODE_W = 2;

	// period divider: 24-bit dividend, divisor and quotient
	localparam int DIV_W  = 24;
	localparam int DEV_W  = FREQ_W + 1;
	localparam int PROD_W = DEV_W + ACC_W;
	localparam int CNT_W  = $clog2(DIV_W);

	// triangle deviation: product over one second as a 10-bit shift, then a
	// multiply by the reciprocal of 15625, exact for dividends below 2^27
	localparam int DEVX_SH  = 10;
	localparam int DEVX_W   = 27;
	localparam int RECIP_W  = 28;
	localparam int RECIP_SH = 41;
	localparam logic [RECIP_W-1:0] DEV_RECIP = RECIP_W'(140737489);

	// iteration count, loaded as count minus one
	localparam logic [CNT_W-1:0] PER_LAST_CNT = CNT_W'(DIV_W - 1);

	// timing constants in 16 MHz clock ticks
	localparam logic [DIV_W-1:0] ONE_SEC_TICKS  = DIV_W'(16000000);
	localparam logic [DIV_W-1:0] HALF_SEC_TICKS = DIV_W'(8000000);

	// limit handling
	localparam logic [FREQ_W-1:0] FREQ_STEP     = FREQ_W'(250);
	localparam logic [FREQ_W-1:0] LIMIT_SWING   = FREQ_W'(500);
	localparam logic [FREQ_W-1:0] UPPER_DEFAULT = FREQ_W'(4900);
	localparam logic [FREQ_W-1:0] LOWER_DEFAULT = FREQ_W'(2600);
	localparam logic [TOP_W-1:0]  TOP_DEFAULT   = TOP_W'(6153);

	// mode codes
	localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UPPER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOWER = 2'd2;

	// item kinds
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_BUTTON = 1'b1;

	// button bit positions
	localparam int BTN_MODE    = 0;
	localparam int BTN_UP      = 1;
	localparam int BTN_DOWN    = 2;
	localparam int BTN_RESTORE = 3;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_DEV,
		ST_FREQ,
		ST_PER,
		ST_WRITE,
		ST_DONE
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic decode;
		logic mul;
		logic scale;
		logic step;
		logic freq;
		logic write;
		logic publish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic sweep;
		logic need_div;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== hdl/siren_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// siren_ctrl
// Sequencer of the tone generator: walks each item through decode, the
// sweep multiply and scaling, the period divider pass and the result transfer.
// ----------------------------------------------------------------------------
module siren_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire siren_pkg::sts_t sts,
	output siren_pkg::cmd_t     cmd
);

	siren_pkg::state_t state_q;
	siren_pkg::state_t state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= siren_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			siren_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = siren_pkg::ST_DECODE;
				end
			end
			siren_pkg::ST_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.sweep) begin
					state_nx = siren_pkg::ST_MUL;
				end else if (sts.need_div) begin
					state_nx = siren_pkg::ST_PER;
				end else begin
					state_nx = siren_pkg::ST_DONE;
				end
			end
			siren_pkg::ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = siren_pkg::ST_DEV;
			end
			siren_pkg::ST_DEV: begin
				cmd.scale = 1'b1;
				state_nx  = siren_pkg::ST_FREQ;
			end
			siren_pkg::ST_FREQ: begin
				cmd.freq = 1'b1;
				state_nx = siren_pkg::ST_PER;
			end
			siren_pkg::ST_PER: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_nx = siren_pkg::ST_WRITE;
				end
			end
			siren_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_nx  = siren_pkg::ST_DONE;
			end
			siren_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_nx    = siren_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = siren_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/siren_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// siren_dp
// Datapath of the tone generator: tone state, button decode, sweep
// accumulator, deviation multiplier and reciprocal scaling, restoring
// period divider and the output register.
// ----------------------------------------------------------------------------
module siren_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire siren_pkg::cmd_t cmd,
	output siren_pkg::sts_t      sts,
	input  wire                  func,
	input  wire [3:0]            buttons_pressed,
	input  wire                  out_ready,
	output logic                 out_valid,
	output logic [12:0]          period_top,
	output logic [11:0]          duty_compare,
	output logic [12:0]          tone_freq,
	output logic [1:0]           mode
);

	localparam int FW = siren_pkg::FREQ_W;
	localparam int DW = siren_pkg::DIV_W;
	localparam int SW = siren_pkg::DEVX_W + siren_pkg::RECIP_W;

	// captured item
	logic                         func_q;
	logic [siren_pkg::BTN_W-1:0]  btn_q;

	// tone state
	logic [siren_pkg::MODE_W-1:0] mode_q;
	logic [FW-1:0]                upper_q;
	logic [FW-1:0]                lower_q;
	logic [siren_pkg::ACC_W-1:0]  accum_q;
	logic [siren_pkg::TOP_W-1:0]  pending_q;
	logic [FW-1:0]                freq_q;
	logic [siren_pkg::TOP_W-1:0]  applied_q;
	logic [FW-1:0]                span_q;
	logic                         load_app_q;

	// triangle deviation
	logic [siren_pkg::DEVX_W-1:0] devx_q;
	logic [siren_pkg::DEV_W-1:0]  dev_q;

	// divider
	logic [DW-1:0]                rem_q;
	logic [DW-1:0]                dq_q;
	logic [DW-1:0]                quo_q;
	logic [DW-1:0]                den_q;
	logic [siren_pkg::CNT_W-1:0]  cnt_q;

	// output register
	logic                         out_valid_q;
	logic [12:0]                  period_top_q;
	logic [11:0]                  duty_compare_q;
	logic [12:0]                  tone_freq_q;
	logic [1:0]                   mode_out_q;

	// limit step for one button event
	function automatic logic [FW-1:0] step_limit(
		input logic [FW-1:0] v,
		input logic [FW-1:0] def,
		input logic [siren_pkg::BTN_W-1:0] btn
	);
		logic [FW-1:0] r;
		r = v;
		if (btn[siren_pkg::BTN_UP] && (r < def + siren_pkg::LIMIT_SWING)) begin
			r = r + siren_pkg::FREQ_STEP;
		end
		if (btn[siren_pkg::BTN_DOWN] && (r > def - siren_pkg::LIMIT_SWING)) begin
			r = r - siren_pkg::FREQ_STEP;
		end
		return r;
	endfunction

	// tick classification
	logic fixed_mode;
	assign fixed_mode = (mode_q == siren_pkg::MODE_UPPER) || (mode_q == siren_pkg::MODE_LOWER);

	// sweep accumulator update, wraps to zero past one second
	logic [siren_pkg::ACC_W:0]   acc_sum;
	logic [siren_pkg::ACC_W-1:0] acc_nx;
	logic [FW-1:0]               span_nx;
	always_comb begin
		acc_sum = {1'b0, accum_q} + (siren_pkg::ACC_W+1)'(pending_q);
		if (acc_sum[siren_pkg::ACC_W-1:0] > siren_pkg::ACC_W'(siren_pkg::ONE_SEC_TICKS)) begin
			acc_nx = '0;
		end else begin
			acc_nx = acc_sum[siren_pkg::ACC_W-1:0];
		end
		span_nx = (upper_q >= lower_q) ? (upper_q - lower_q) : '0;
	end

	// button decode: restore, mode cycle, limit steps, fixed reload
	logic [siren_pkg::MODE_W-1:0] m0, m1;
	logic [FW-1:0]                up0, lo0, up1, lo1;
	logic                         btn_load;
	logic [FW-1:0]                btn_freq;
	always_comb begin
		m0  = btn_q[siren_pkg::BTN_RESTORE] ? siren_pkg::MODE_SWEEP : mode_q;
		up0 = btn_q[siren_pkg::BTN_RESTORE] ? siren_pkg::UPPER_DEFAULT : upper_q;
		lo0 = btn_q[siren_pkg::BTN_RESTORE] ? siren_pkg::LOWER_DEFAULT : lower_q;
		m1  = m0;
		up1 = up0;
		lo1 = lo0;
		case (m0)
			siren_pkg::MODE_UPPER: begin
				if (btn_q[siren_pkg::BTN_MODE]) begin
					m1 = siren_pkg::MODE_LOWER;
				end
				up1 = step_limit(up0, siren_pkg::UPPER_DEFAULT, btn_q);
			end
			siren_pkg::MODE_LOWER: begin
				if (btn_q[siren_pkg::BTN_MODE]) begin
					m1 = siren_pkg::MODE_SWEEP;
				end
				lo1 = step_limit(lo0, siren_pkg::LOWER_DEFAULT, btn_q);
			end
			default: begin
				m1 = btn_q[siren_pkg::BTN_MODE] ? siren_pkg::MODE_UPPER : siren_pkg::MODE_SWEEP;
			end
		endcase
		// leaving fixed-low keeps the reload taken at the start of the event
		btn_load = 1'b1;
		if (m1 == siren_pkg::MODE_UPPER) begin
			btn_freq = up1;
		end else if (m1 == siren_pkg::MODE_LOWER) begin
			btn_freq = lo1;
		end else if (m0 == siren_pkg::MODE_LOWER) begin
			btn_freq = lo0;
		end else begin
			btn_load = 1'b0;
			btn_freq = freq_q;
		end
	end

	logic [FW-1:0] load_freq;
	assign load_freq = (func_q == siren_pkg::FUNC_BUTTON) ? btn_freq :
		((mode_q == siren_pkg::MODE_UPPER) ? upper_q : lower_q);

	// sweep frequency from the registered deviation
	logic [siren_pkg::DEV_W-1:0] dev;
	logic [siren_pkg::DEV_W-1:0] dev_over;
	logic [FW-1:0]               freq_calc;
	always_comb begin
		dev      = dev_q;
		dev_over = '0;
		if (accum_q > siren_pkg::ACC_W'(siren_pkg::HALF_SEC_TICKS)) begin
			if (dev >= {1'b0, span_q}) begin
				dev_over = dev - {1'b0, span_q};
			end
			if ({1'b0, upper_q} >= dev_over) begin
				freq_calc = FW'({1'b0, upper_q} - dev_over);
			end else begin
				freq_calc = '0;
			end
		end else begin
			freq_calc = FW'({1'b0, lower_q} + dev);
		end
	end

	// deviation product, 2 * span * accumulator
	logic [siren_pkg::PROD_W-1:0] prod;
	assign prod = siren_pkg::PROD_W'({span_q, 1'b0}) * siren_pkg::PROD_W'(accum_q);

	// product over one second: shifted product times the reciprocal of 15625
	logic [SW-1:0] scaled;
	assign scaled = SW'(devx_q) * SW'(siren_pkg::DEV_RECIP);

	// one restoring divider step
	logic [DW:0]   trial;
	logic [DW+1:0] diff;
	logic          fits;
	always_comb begin
		trial = {rem_q, dq_q[DW-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		fits  = !diff[DW+1];
	end

	// period result, zero for a zero divisor
	logic [siren_pkg::TOP_W-1:0] per_result;
	assign per_result = (den_q == '0) ? '0 : quo_q[siren_pkg::TOP_W-1:0];

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			btn_q  <= buttons_pressed;
		end
	end

	// tone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= siren_pkg::MODE_SWEEP;
			upper_q    <= siren_pkg::UPPER_DEFAULT;
			lower_q    <= siren_pkg::LOWER_DEFAULT;
			accum_q    <= '0;
			pending_q  <= siren_pkg::TOP_DEFAULT;
			freq_q     <= siren_pkg::LOWER_DEFAULT;
			applied_q  <= siren_pkg::TOP_DEFAULT;
			load_app_q <= 1'b0;
		end else begin
			if (cmd.decode) begin
				if (func_q == siren_pkg::FUNC_BUTTON) begin
					mode_q  <= m1;
					upper_q <= up1;
					lower_q <= lo1;
				end
				if (sts.sweep) begin
					applied_q <= pending_q;
					accum_q   <= acc_nx;
				end else if (sts.need_div) begin
					freq_q <= load_freq;
				end
				load_app_q <= !sts.sweep;
			end
			if (cmd.freq) begin
				freq_q <= freq_calc;
			end
			if (cmd.write) begin
				pending_q <= per_result;
				if (load_app_q) begin
					applied_q <= per_result;
				end
			end
		end
	end

	// sweep span, deviation and divider registers
	always_ff @(posedge clk) begin
		if (cmd.decode && sts.sweep) begin
			span_q <= span_nx;
		end
		if (cmd.mul) begin
			devx_q <= prod[siren_pkg::DEVX_SH+siren_pkg::DEVX_W-1:siren_pkg::DEVX_SH];
		end
		if (cmd.scale) begin
			dev_q <= scaled[siren_pkg::RECIP_SH+siren_pkg::DEV_W-1:siren_pkg::RECIP_SH];
		end
		if ((cmd.decode && sts.need_div) || cmd.freq) begin
			rem_q <= '0;
			dq_q  <= siren_pkg::ONE_SEC_TICKS;
			quo_q <= '0;
			den_q <= DW'(cmd.freq ? freq_calc : load_freq);
		end else if (cmd.step) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			dq_q  <= {dq_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	// iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if ((cmd.decode && sts.need_div) || cmd.freq) begin
			cnt_q <= siren_pkg::PER_LAST_CNT;
		end else if (cmd.step && (cnt_q != '0)) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output register and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			period_top_q   <= applied_q;
			duty_compare_q <= applied_q[12:1];
			tone_freq_q    <= freq_q;
			mode_out_q     <= mode_q;
		end
	end

	// status to the controller
	always_comb begin
		sts.sweep    = (func_q == siren_pkg::FUNC_TICK) && !fixed_mode;
		sts.need_div = (func_q == siren_pkg::FUNC_TICK) ? fixed_mode : btn_load;
		sts.div_last = (cnt_q == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid    = out_valid_q;
	assign period_top   = period_top_q;
	assign duty_compare = duty_compare_q;
	assign tone_freq    = tone_freq_q;
	assign mode         = mode_out_q;

`ifndef ASSERT_OFF
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= siren_pkg::MODE_LOWER)
		else $error("mode register holds an unused code");

	a_limits: assert property (@(posedge clk) disable iff (!arst_n)
		(upper_q >= siren_pkg::UPPER_DEFAULT - siren_pkg::LIMIT_SWING)
		&& (upper_q <= siren_pkg::UPPER_DEFAULT + siren_pkg::LIMIT_SWING)
		&& (lower_q >= siren_pkg::LOWER_DEFAULT - siren_pkg::LIMIT_SWING)
		&& (lower_q <= siren_pkg::LOWER_DEFAULT + siren_pkg::LIMIT_SWING))
		else $error("frequency limit left its adjust window");

	a_accum: assert property (@(posedge clk) disable iff (!arst_n)
		accum_q <= siren_pkg::ACC_W'(siren_pkg::ONE_SEC_TICKS))
		else $error("sweep accumulator past one second");

	a_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(freq_q >= lower_q) || (freq_q >= siren_pkg::LOWER_DEFAULT - siren_pkg::LIMIT_SWING))
		else $error("tone frequency below the lower range");

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid_q || out_ready))
		else $error("result overwritten before its transfer");
`endif

endmodule
`default_nettype wire

// ===== hdl/siren_triangle_sweep_tone.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// siren_triangle_sweep_tone
// Siren tone period generator: a sequencer and a datapath with one
// bit-serial period divider.
// ----------------------------------------------------------------------------
// Each accepted item gives one result. Items are handled one at a time; a
// new item is taken only after the last one has offered its result. A sweep
// tick passes through decode, one multiply, one reciprocal multiply that
// scales the product to the triangle deviation, the frequency step, 24
// divider steps for the period and the store and offer of the result. A tick
// in a fixed mode, and a button event that reloads a fixed limit, passes
// through decode, one 24-step period division and the store and offer; a
// button event with no reload goes from decode straight to the offer. The
// restoring period divider retires one quotient bit a cycle. A finished
// result waits in the output register; the next item is taken meanwhile and
// holds at its last step only while that register is still full.
// ----------------------------------------------------------------------------
module siren_triangle_sweep_tone (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         func,
	input  wire [3:0]   buttons_pressed,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [12:0] period_top,
	output logic [11:0] duty_compare,
	output logic [12:0] tone_freq,
	output logic [1:0]  mode
);

	siren_pkg::cmd_t cmd;
	siren_pkg::sts_t sts;

	// sequencer
	siren_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	siren_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.buttons_pressed (buttons_pressed),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.period_top      (period_top),
		.duty_compare    (duty_compare),
		.tone_freq       (tone_freq),
		.mode            (mode)
	);

endmodule
`default_nettype wire

// ===== dv/tb_siren_triangle_sweep_tone.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_siren_triangle_sweep_tone
// Self-checking bench for the siren tone period generator. A directed pass
// walks the mode cycle, limit stepping and its bounds, and restore presses.
// Random ticks and button events follow, then a sweep run at the widest
// limits. Every result is checked against a behavioral tone model. The input
// side idles and the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_siren_triangle_sweep_tone;

	localparam int CYCLE_LIMIT = 3000000;

	// button masks
	localparam logic [3:0] PRESS_NONE    = 4'b0000;
	localparam logic [3:0] PRESS_MODE    = 4'(1 << siren_pkg::BTN_MODE);
	localparam logic [3:0] PRESS_UP      = 4'(1 << siren_pkg::BTN_UP);
	localparam logic [3:0] PRESS_DOWN    = 4'(1 << siren_pkg::BTN_DOWN);
	localparam logic [3:0] PRESS_RESTORE = 4'(1 << siren_pkg::BTN_RESTORE);

	typedef struct packed {
		logic [12:0] top;
		logic [11:0] duty;
		logic [12:0] freq;
		logic [1:0]  mode;
	} tone_t;

	// tone model and expected-result store
	class siren_tone_model;
		logic [1:0]  mode_q;
		logic [12:0] upper_q;
		logic [12:0] lower_q;
		logic [12:0] freq_q;
		logic [12:0] pending_q;
		logic [12:0] applied_q;
		logic [24:0] accum_q;
		tone_t       expected_tones[$];
		int          errors;
		int          checked;
		int          ticks;
		int          presses;
		int          wraps;

		function new();
			mode_q    = siren_pkg::MODE_SWEEP;
			upper_q   = siren_pkg::UPPER_DEFAULT;
			lower_q   = siren_pkg::LOWER_DEFAULT;
			freq_q    = siren_pkg::LOWER_DEFAULT;
			pending_q = period_for(siren_pkg::LOWER_DEFAULT);
			applied_q = pending_q;
			accum_q   = '0;
			errors    = 0;
			checked   = 0;
			ticks     = 0;
			presses   = 0;
			wraps     = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("%s", msg);
		endfunction

		// one-second tick count over frequency, kept to 13 bits
		function logic [12:0] period_for(logic [12:0] f);
			int unsigned q;
			if (f == 0)
				return '0;
			q = 32'(siren_pkg::ONE_SEC_TICKS) / 32'(f);
			return q[12:0];
		endfunction

		function void load_fixed(logic [12:0] f);
			freq_q    = f;
			pending_q = period_for(f);
			applied_q = pending_q;
		endfunction

		// up then down, each held within the swing around its default
		function logic [12:0] step_limit(logic [12:0] v, logic [12:0] def, logic [3:0] btn);
			logic [12:0] r;
			r = v;
			if (btn[siren_pkg::BTN_UP] && r < def + siren_pkg::LIMIT_SWING)
				r = r + siren_pkg::FREQ_STEP;
			if (btn[siren_pkg::BTN_DOWN] && r > def - siren_pkg::LIMIT_SWING)
				r = r - siren_pkg::FREQ_STEP;
			return r;
		endfunction

		// triangle sweep: rise over the first half second, fall over the second
		function void sweep_tick();
			logic [25:0]     sum;
			int unsigned     span;
			int unsigned     dev;
			int unsigned     f;
			longint unsigned prod;
			applied_q = pending_q;
			sum = {1'b0, accum_q} + 26'(pending_q);
			accum_q = sum[24:0];
			if (accum_q > 25'(siren_pkg::ONE_SEC_TICKS)) begin
				accum_q = '0;
				wraps++;
			end
			if (upper_q >= lower_q)
				span = upper_q - lower_q;
			else
				span = 0;
			prod = 64'(2 * span) * 64'(accum_q);
			dev = 32'(prod / 64'(siren_pkg::ONE_SEC_TICKS));
			if (accum_q > 25'(siren_pkg::HALF_SEC_TICKS)) begin
				dev = (dev >= span) ? dev - span : 0;
				f = (upper_q >= dev) ? upper_q - dev : 0;
			end else begin
				f = lower_q + dev;
			end
			freq_q = f[12:0];
			pending_q = period_for(freq_q);
		endfunction

		function void press(logic [3:0] btn);
			if (btn[siren_pkg::BTN_RESTORE]) begin
				mode_q  = siren_pkg::MODE_SWEEP;
				upper_q = siren_pkg::UPPER_DEFAULT;
				lower_q = siren_pkg::LOWER_DEFAULT;
			end
			// limit steps apply to the mode the event began in
			if (mode_q == siren_pkg::MODE_UPPER) begin
				load_fixed(upper_q);
				if (btn[siren_pkg::BTN_MODE])
					mode_q = siren_pkg::MODE_LOWER;
				upper_q = step_limit(upper_q, siren_pkg::UPPER_DEFAULT, btn);
			end else if (mode_q == siren_pkg::MODE_LOWER) begin
				load_fixed(lower_q);
				if (btn[siren_pkg::BTN_MODE])
					mode_q = siren_pkg::MODE_SWEEP;
				lower_q = step_limit(lower_q, siren_pkg::LOWER_DEFAULT, btn);
			end else begin
				mode_q = siren_pkg::MODE_SWEEP;
				if (btn[siren_pkg::BTN_MODE])
					mode_q = siren_pkg::MODE_UPPER;
			end
			if (mode_q == siren_pkg::MODE_UPPER)
				load_fixed(upper_q);
			else if (mode_q == siren_pkg::MODE_LOWER)
				load_fixed(lower_q);
		endfunction

		// accepted input: advance the model and queue the result it implies
		function void note_item(logic kind, logic [3:0] btn);
			if (kind == siren_pkg::FUNC_TICK) begin
				ticks++;
				if (mode_q == siren_pkg::MODE_UPPER)
					load_fixed(upper_q);
				else if (mode_q == siren_pkg::MODE_LOWER)
					load_fixed(lower_q);
				else
					sweep_tick();
			end else begin
				presses++;
				press(btn);
			end
			expected_tones.push_back('{applied_q, applied_q[12:1], freq_q, mode_q});
		endfunction

		function void check_result(logic [12:0] top, logic [11:0] duty, logic [12:0] freq,
				logic [1:0] md);
			tone_t want;
			if (expected_tones.size() == 0) begin
				flag($sformatf("unexpected result: top=%0d duty=%0d freq=%0d mode=%0d",
					top, duty, freq, md));
				return;
			end
			want = expected_tones.pop_front();
			if (top !== want.top || duty !== want.duty || freq !== want.freq ||
					md !== want.mode)
				flag($sformatf({"result %0d mismatch: expected top=%0d duty=%0d freq=%0d ",
					"mode=%0d, got top=%0d duty=%0d freq=%0d mode=%0d"}, checked,
					want.top, want.duty, want.freq, want.mode, top, duty, freq, md));
			checked++;
		endfunction
	endclass

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        func            = siren_pkg::FUNC_TICK;
	logic [3:0]  buttons_pressed = PRESS_NONE;
	logic        out_ready       = 1'b0;
	wire         in_ready;
	wire         out_valid;
	wire  [12:0] period_top;
	wire  [11:0] duty_compare;
	wire  [12:0] tone_freq;
	wire  [1:0]  mode;

	siren_tone_model tones = new();
	bit idle_on = 1'b1;
	int stall_left = 0;

	siren_triangle_sweep_tone dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.buttons_pressed (buttons_pressed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.period_top      (period_top),
		.duty_compare    (duty_compare),
		.tone_freq       (tone_freq),
		.mode            (mode)
	);

	always #2 clk = ~clk;

	// result side back-pressure: mostly single-cycle stalls, now and then a long one
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 10) begin
			stall_left <= ($urandom_range(0, 49) == 0) ? $urandom_range(5, 50) : 0;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result transfer check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tones.check_result(period_top, duty_compare, tone_freq, mode);
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// one input transfer, with an optional random gap in front
	task automatic send_item(input logic kind, input logic [3:0] btn);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 99) < 13)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 60) : $urandom_range(1, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid        <= 1'b1;
		func            <= kind;
		buttons_pressed <= btn;
		do
			@(posedge clk);
		while (!in_ready);
		tones.note_item(kind, btn);
	endtask

	// buttons ride along on ticks and must be ignored there
	task automatic tick_item();
		send_item(siren_pkg::FUNC_TICK, 4'($urandom_range(0, 15)));
	endtask

	task automatic press_item(input logic [3:0] btn);
		send_item(siren_pkg::FUNC_BUTTON, btn);
	endtask

	initial begin
		logic [3:0] btn;
		int         guard;
		int         left;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, sweep-mode presses, both limits to their bounds
		tick_item();
		press_item(PRESS_NONE);
		press_item(PRESS_UP | PRESS_DOWN);
		press_item(PRESS_MODE);
		tick_item();
		repeat (3) press_item(PRESS_UP);
		repeat (5) press_item(PRESS_DOWN);
		press_item(PRESS_UP | PRESS_DOWN);
		press_item(PRESS_MODE | PRESS_UP);
		tick_item();
		repeat (3) press_item(PRESS_DOWN);
		press_item(PRESS_UP);
		press_item(PRESS_MODE | PRESS_DOWN);
		tick_item();
		press_item(PRESS_RESTORE);
		press_item(PRESS_RESTORE | PRESS_MODE);
		press_item(PRESS_RESTORE | PRESS_MODE | PRESS_UP | PRESS_DOWN);
		tick_item();
		press_item(PRESS_RESTORE);

		// random mix, with a stretch free of idling on both sides
		for (int i = 0; i < 1100; i++) begin
			idle_on = !(i >= 400 && i < 700);
			if ($urandom_range(0, 99) < 70) begin
				tick_item();
			end else begin
				btn[siren_pkg::BTN_MODE]    = $urandom_range(0, 99) < 40;
				btn[siren_pkg::BTN_UP]      = $urandom_range(0, 99) < 40;
				btn[siren_pkg::BTN_DOWN]    = $urandom_range(0, 99) < 40;
				btn[siren_pkg::BTN_RESTORE] = $urandom_range(0, 99) < 8;
				press_item(btn);
			end
		end
		idle_on = 1'b1;

		// widest limits, then a run of sweep ticks
		press_item(PRESS_RESTORE);
		press_item(PRESS_MODE);
		repeat (2) press_item(PRESS_UP);
		press_item(PRESS_MODE);
		repeat (2) press_item(PRESS_DOWN);
		press_item(PRESS_MODE);
		repeat (60) tick_item();

		// drain
		in_valid <= 1'b0;
		guard = 0;
		while (tones.expected_tones.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		left = tones.expected_tones.size();
		if (left != 0)
			tones.flag($sformatf("%0d expected results never arrived", left));

		$display("tb: %0d results checked over %0d ticks and %0d button events",
			tones.checked, tones.ticks, tones.presses);
		$display("tb: tick accumulator wrapped %0d times, %0d mismatches",
			tones.wraps, tones.errors);
		if (tones.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
`default_nettype wire
